// ===== src/sci_pkg.sv =====
// Shared types and constants of the segment/circle intersection block.
// No dependencies; every other source file but sci_checker refers to it by scoped names.
package sci_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_reg_e;

  localparam int CFG_INDEX_W  = 2;
  localparam int RADIUS_RESET = 65536;

  // Status that rides with a segment from the products to the square root
  typedef struct packed {
    logic azero;  // segment of zero length
    logic hneg;   // h below zero
    logic cneg;   // c below zero
    logic dneg;   // discriminant below zero
  } pre_flags_t;

  // Status that rides with a segment through the dividers
  typedef struct packed {
    logic degen;   // zero length, or q equal to zero with the discriminant not below zero
    logic ok1;     // first root c/q lies in [0, 1]
    logic ok2;     // second root q/a lies in [0, 1]
    logic whole1;  // first root is exactly 1.0
    logic whole2;  // second root is exactly 1.0
  } fin_flags_t;

endpackage

// ===== src/sci_front.sv =====
// Front pipeline: differences, exact products, and the discriminant h^2 - a*c.
// Uses sci_pkg for the flag struct; feeds the square-root cell chain.
module sci_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       load,
  input  logic [COORD_WIDTH-1:0]     sx,
  input  logic [COORD_WIDTH-1:0]     sy,
  input  logic [COORD_WIDTH-1:0]     ex,
  input  logic [COORD_WIDTH-1:0]     ey,
  input  logic [COORD_WIDTH-1:0]     cx,
  input  logic [COORD_WIDTH-1:0]     cy,
  input  logic [COORD_WIDTH-2:0]     rad,
  output logic                       valid,
  output logic [2*COORD_WIDTH+1:0]   a_out,
  output logic [2*COORD_WIDTH+1:0]   hmag_out,
  output logic [2*COORD_WIDTH+1:0]   cmag_out,
  output logic [4*COORD_WIDTH+3:0]   disc_out,
  output sci_pkg::pre_flags_t        flags_out
);

  localparam int W      = COORD_WIDTH;
  localparam int DIF_W  = W + 1;
  localparam int PROD_W = 2 * W + 2;
  localparam int MAG_W  = 2 * W + 2;
  localparam int HALF_W = W + 1;
  localparam int DISC_W = 4 * W + 4;
  localparam int RR_W   = 2 * W - 2;

  logic [6:0] vld;

  logic [DIF_W-1:0] dx, dy, px, py;

  logic signed [PROD_W-1:0] p_dxx, p_dyy, p_hx, p_hy, p_pxx, p_pyy;
  logic [RR_W-1:0]          p_rr;

  logic [MAG_W-1:0] s2_a;
  logic [MAG_W:0]   s2_h, s2_c;
  logic [MAG_W:0]   h_abs, c_abs;

  logic [MAG_W-1:0]    s3_a, s3_hmag, s3_cmag;
  sci_pkg::pre_flags_t s3_fl;

  logic [2*HALF_W-1:0] s4_hhh, s4_hhl, s4_hll, s4_ahh, s4_ahl, s4_alh, s4_all;
  logic [MAG_W-1:0]    s4_a, s4_hmag, s4_cmag;
  sci_pkg::pre_flags_t s4_fl;

  logic [2*HALF_W:0]   ac_mid;
  logic [DISC_W-1:0]   hsq_sum, ac_sum;

  logic [DISC_W-1:0]   s5_hsq, s5_ac;
  logic [MAG_W-1:0]    s5_a, s5_hmag, s5_cmag;
  sci_pkg::pre_flags_t s5_fl;

  logic [DISC_W:0]     disc_full;

  // Advance the stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], load};
    end
  end

  assign valid = vld[6];

  // Direction and offset from the center
  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {ex[W-1], ex} - {sx[W-1], sx};
      dy <= {ey[W-1], ey} - {sy[W-1], sy};
      px <= {sx[W-1], sx} - {cx[W-1], cx};
      py <= {sy[W-1], sy} - {cy[W-1], cy};
    end
  end

  // Exact products of the differences
  always_ff @(posedge clk) begin
    if (en) begin
      p_dxx <= $signed(dx) * $signed(dx);
      p_dyy <= $signed(dy) * $signed(dy);
      p_hx  <= $signed(px) * $signed(dx);
      p_hy  <= $signed(py) * $signed(dy);
      p_pxx <= $signed(px) * $signed(px);
      p_pyy <= $signed(py) * $signed(py);
      p_rr  <= rad * rad;
    end
  end

  // Quadratic coefficients a, h and c
  always_ff @(posedge clk) begin
    if (en) begin
      s2_a <= $unsigned(p_dxx) + $unsigned(p_dyy);
      s2_h <= {p_hx[PROD_W-1], p_hx} + {p_hy[PROD_W-1], p_hy};
      s2_c <= {1'b0, p_pxx} + {1'b0, p_pyy} - {{(MAG_W+1-RR_W){1'b0}}, p_rr};
    end
  end

  assign h_abs = s2_h[MAG_W] ? ~s2_h + 1'b1 : s2_h;
  assign c_abs = s2_c[MAG_W] ? ~s2_c + 1'b1 : s2_c;

  // Split into sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      s3_a        <= s2_a;
      s3_hmag     <= h_abs[MAG_W-1:0];
      s3_cmag     <= c_abs[MAG_W-1:0];
      s3_fl.azero <= (s2_a == '0);
      s3_fl.hneg  <= s2_h[MAG_W];
      s3_fl.cneg  <= s2_c[MAG_W];
      s3_fl.dneg  <= 1'b0;
    end
  end

  // Half-width partial products of h*h and a*|c|
  always_ff @(posedge clk) begin
    if (en) begin
      s4_hhh  <= s3_hmag[MAG_W-1:HALF_W] * s3_hmag[MAG_W-1:HALF_W];
      s4_hhl  <= s3_hmag[MAG_W-1:HALF_W] * s3_hmag[HALF_W-1:0];
      s4_hll  <= s3_hmag[HALF_W-1:0] * s3_hmag[HALF_W-1:0];
      s4_ahh  <= s3_a[MAG_W-1:HALF_W] * s3_cmag[MAG_W-1:HALF_W];
      s4_ahl  <= s3_a[MAG_W-1:HALF_W] * s3_cmag[HALF_W-1:0];
      s4_alh  <= s3_a[HALF_W-1:0] * s3_cmag[MAG_W-1:HALF_W];
      s4_all  <= s3_a[HALF_W-1:0] * s3_cmag[HALF_W-1:0];
      s4_a    <= s3_a;
      s4_hmag <= s3_hmag;
      s4_cmag <= s3_cmag;
      s4_fl   <= s3_fl;
    end
  end

  assign ac_mid  = {1'b0, s4_ahl} + {1'b0, s4_alh};
  assign hsq_sum = {s4_hhh, s4_hll} + (DISC_W'({s4_hhl, 1'b0}) << HALF_W);
  assign ac_sum  = {s4_ahh, s4_all} + (DISC_W'(ac_mid) << HALF_W);

  // Assemble the two full products
  always_ff @(posedge clk) begin
    if (en) begin
      s5_hsq  <= hsq_sum;
      s5_ac   <= ac_sum;
      s5_a    <= s4_a;
      s5_hmag <= s4_hmag;
      s5_cmag <= s4_cmag;
      s5_fl   <= s4_fl;
    end
  end

  assign disc_full = s5_fl.cneg ? {1'b0, s5_hsq} + {1'b0, s5_ac}
                                : {1'b0, s5_hsq} - {1'b0, s5_ac};

  // Discriminant and its sign
  always_ff @(posedge clk) begin
    if (en) begin
      disc_out        <= disc_full[DISC_W-1:0];
      a_out           <= s5_a;
      hmag_out        <= s5_hmag;
      cmag_out        <= s5_cmag;
      flags_out.azero <= s5_fl.azero;
      flags_out.hneg  <= s5_fl.hneg;
      flags_out.cneg  <= s5_fl.cneg;
      flags_out.dneg  <= !s5_fl.cneg && disc_full[DISC_W];
    end
  end

endmodule

// ===== src/sci_sqrt_cell.sv =====
// One cell of the square-root chain: retires one root bit per cycle while en is high.
// Uses sci_pkg for the flag struct that rides along with the operand.
module sci_sqrt_cell #(
  parameter int DISC_W = 132,
  parameter int SIDE_W = 198
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  i_valid,
  input  sci_pkg::pre_flags_t   i_flags,
  input  logic [SIDE_W-1:0]     i_side,
  input  logic [DISC_W-1:0]     i_op,
  input  logic [DISC_W/2:0]     i_rem,
  input  logic [DISC_W/2-1:0]   i_root,
  output logic                  o_valid,
  output sci_pkg::pre_flags_t   o_flags,
  output logic [SIDE_W-1:0]     o_side,
  output logic [DISC_W-1:0]     o_op,
  output logic [DISC_W/2:0]     o_rem,
  output logic [DISC_W/2-1:0]   o_root
);

  localparam int SQ_W = DISC_W / 2;

  logic [SQ_W+2:0] rem_sh, trial;
  logic            take;

  // Bring down the next two operand bits and try the next root bit
  assign rem_sh = {i_rem, i_op[DISC_W-1:DISC_W-2]};
  assign trial  = {1'b0, i_root, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_flags <= i_flags;
      o_side  <= i_side;
      o_op    <= {i_op[DISC_W-3:0], 2'b00};
      o_rem   <= take ? (SQ_W+1)'(rem_sh - trial) : rem_sh[SQ_W:0];
      o_root  <= {i_root[SQ_W-2:0], take};
    end
  end

endmodule

// ===== src/sci_div_cell.sv =====
// One cell of the twin divider chain: one quotient bit of c/q and of q/a.
// Uses sci_pkg for the root status that travels with the quotients.
module sci_div_cell #(
  parameter int NUM_W = 67,
  parameter int ACC_W = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 i_valid,
  input  sci_pkg::fin_flags_t  i_flags,
  input  logic [NUM_W-1:0]     i_rem1,
  input  logic [NUM_W-1:0]     i_den1,
  input  logic [ACC_W-1:0]     i_acc1,
  input  logic [NUM_W-1:0]     i_rem2,
  input  logic [NUM_W-1:0]     i_den2,
  input  logic [ACC_W-1:0]     i_acc2,
  output logic                 o_valid,
  output sci_pkg::fin_flags_t  o_flags,
  output logic [NUM_W-1:0]     o_rem1,
  output logic [NUM_W-1:0]     o_den1,
  output logic [ACC_W-1:0]     o_acc1,
  output logic [NUM_W-1:0]     o_rem2,
  output logic [NUM_W-1:0]     o_den2,
  output logic [ACC_W-1:0]     o_acc2
);

  // Restoring step: top bit is the quotient bit, the rest the new remainder
  function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                              input logic [NUM_W-1:0] den);
    logic [NUM_W:0] sh;
    logic [NUM_W:0] dn;
    logic [NUM_W:0] diff;
    sh   = {rem, 1'b0};
    dn   = {1'b0, den};
    diff = sh - dn;
    if (sh >= dn) begin
      return {1'b1, diff[NUM_W-1:0]};
    end
    return {1'b0, sh[NUM_W-1:0]};
  endfunction

  logic [NUM_W:0] step1, step2;

  assign step1 = div_step(i_rem1, i_den1);
  assign step2 = div_step(i_rem2, i_den2);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_flags <= i_flags;
      o_rem1  <= step1[NUM_W-1:0];
      o_den1  <= i_den1;
      o_acc1  <= {i_acc1[ACC_W-2:0], step1[NUM_W]};
      o_rem2  <= step2[NUM_W-1:0];
      o_den2  <= i_den2;
      o_acc2  <= {i_acc2[ACC_W-2:0], step2[NUM_W]};
    end
  end

endmodule

// ===== src/segment_circle_intersect.sv =====
// Segment/circle intersection. Takes one segment per cycle while in_ready is
// high and returns, per segment, the count of crossings, the crossing parameters
// t in [0, 1] (nearest first, Q1.T) and a degenerate flag. The pipeline is fully
// exact: a seven-stage product and discriminant front end, a chain of
// 2*COORD_WIDTH+2 square-root cells (one root bit each), one stage forming q, a
// chain of T_FRAC_BITS+1 twin divider cells (one quotient bit each) and the
// output register. A segment is accepted every cycle while in_ready is high.
// Depends on sci_pkg, sci_front, sci_sqrt_cell and sci_div_cell.
module segment_circle_intersect #(
  parameter int COORD_WIDTH = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sci_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [COORD_WIDTH-1:0]           cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [COORD_WIDTH-1:0]           start_x,
  input  logic [COORD_WIDTH-1:0]           start_y,
  input  logic [COORD_WIDTH-1:0]           end_x,
  input  logic [COORD_WIDTH-1:0]           end_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       hit_count,
  output logic [T_FRAC_BITS:0]             t_near,
  output logic [T_FRAC_BITS:0]             t_far,
  output logic                             degenerate
);

  localparam int W      = COORD_WIDTH;
  localparam int MAG_W  = 2 * W + 2;
  localparam int DISC_W = 4 * W + 4;
  localparam int SQ_W   = DISC_W / 2;
  localparam int Q_W    = MAG_W + 1;
  localparam int SIDE_W = 3 * MAG_W;
  localparam int TW     = T_FRAC_BITS + 1;
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic adv;

  logic [W-1:0] center_x, center_y;
  logic [W-2:0] circle_radius;

  // Front end outputs
  logic                front_valid;
  logic [MAG_W-1:0]    front_a, front_hmag, front_cmag;
  logic [DISC_W-1:0]   front_disc;
  sci_pkg::pre_flags_t front_fl;

  // Square-root chain taps
  logic                sq_v    [SQ_W+1];
  sci_pkg::pre_flags_t sq_fl   [SQ_W+1];
  logic [SIDE_W-1:0]   sq_side [SQ_W+1];
  logic [DISC_W-1:0]   sq_op   [SQ_W+1];
  logic [SQ_W:0]       sq_rem  [SQ_W+1];
  logic [SQ_W-1:0]     sq_root [SQ_W+1];

  // q stage
  logic                q1_valid;
  sci_pkg::pre_flags_t q1_fl;
  logic [MAG_W-1:0]    q1_a, q1_cmag;
  logic [Q_W-1:0]      q1_qmag;
  logic                q1_szero;

  logic [Q_W-1:0]      a_ext, c_ext;
  logic                qzero, live, sign_ok;
  sci_pkg::fin_flags_t setup_fl;

  // Divider chain taps
  logic                dv_v    [TW+1];
  sci_pkg::fin_flags_t dv_fl   [TW+1];
  logic [Q_W-1:0]      dv_rem1 [TW+1];
  logic [Q_W-1:0]      dv_den1 [TW+1];
  logic [TW-1:0]       dv_acc1 [TW+1];
  logic [Q_W-1:0]      dv_rem2 [TW+1];
  logic [Q_W-1:0]      dv_den2 [TW+1];
  logic [TW-1:0]       dv_acc2 [TW+1];

  // Result assembly
  logic [TW-1:0] t1, t2, near_next, far_next;
  logic [1:0]    count_next;

  function automatic logic [TW-1:0] t_round(input logic whole, input logic [TW-1:0] acc);
    logic [TW:0] sum;
    sum = {1'b0, acc} + 1'b1;
    return whole ? T_ONE : sum[TW:1];
  endfunction

  // Whole pipe moves unless a held result would be overwritten
  assign adv      = out_ready || !out_valid || !dv_v[TW];
  assign in_ready = adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      circle_radius <= (W-1)'(sci_pkg::RADIUS_RESET);
    end else if (cfg_write) begin
      case (sci_pkg::cfg_reg_e'(cfg_index))
        sci_pkg::CFG_CENTER_X: center_x      <= cfg_data;
        sci_pkg::CFG_CENTER_Y: center_y      <= cfg_data;
        sci_pkg::CFG_RADIUS:   circle_radius <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  sci_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .load      (in_valid),
    .sx        (start_x),
    .sy        (start_y),
    .ex        (end_x),
    .ey        (end_y),
    .cx        (center_x),
    .cy        (center_y),
    .rad       (circle_radius),
    .valid     (front_valid),
    .a_out     (front_a),
    .hmag_out  (front_hmag),
    .cmag_out  (front_cmag),
    .disc_out  (front_disc),
    .flags_out (front_fl)
  );

  assign sq_v[0]    = front_valid;
  assign sq_fl[0]   = front_fl;
  assign sq_side[0] = {front_a, front_hmag, front_cmag};
  assign sq_op[0]   = front_disc;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    sci_sqrt_cell #(
      .DISC_W (DISC_W),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .i_valid (sq_v[k]),
      .i_flags (sq_fl[k]),
      .i_side  (sq_side[k]),
      .i_op    (sq_op[k]),
      .i_rem   (sq_rem[k]),
      .i_root  (sq_root[k]),
      .o_valid (sq_v[k+1]),
      .o_flags (sq_fl[k+1]),
      .o_side  (sq_side[k+1]),
      .o_op    (sq_op[k+1]),
      .o_rem   (sq_rem[k+1]),
      .o_root  (sq_root[k+1])
    );
  end

  // Form |q| = |h| + s; the sign of q is the opposite of the sign of h
  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid <= 1'b0;
    end else if (adv) begin
      q1_valid <= sq_v[SQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_fl    <= sq_fl[SQ_W];
      q1_a     <= sq_side[SQ_W][3*MAG_W-1:2*MAG_W];
      q1_cmag  <= sq_side[SQ_W][MAG_W-1:0];
      q1_qmag  <= {1'b0, sq_side[SQ_W][2*MAG_W-1:MAG_W]} + {1'b0, sq_root[SQ_W]};
      q1_szero <= (sq_root[SQ_W] == '0);
    end
  end

  // Decide which roots lie in [0, 1] and load the dividers
  assign a_ext   = {1'b0, q1_a};
  assign c_ext   = {1'b0, q1_cmag};
  assign qzero   = (q1_qmag == '0);
  assign live    = !q1_fl.azero && !q1_fl.dneg && !qzero;
  assign sign_ok = (q1_cmag == '0) || (q1_fl.cneg == !q1_fl.hneg);

  always_comb begin
    setup_fl.degen  = q1_fl.azero || (!q1_fl.dneg && qzero);
    setup_fl.ok1    = live && sign_ok && (c_ext <= q1_qmag);
    setup_fl.ok2    = live && !q1_szero && q1_fl.hneg && (a_ext >= q1_qmag);
    setup_fl.whole1 = (c_ext == q1_qmag);
    setup_fl.whole2 = (a_ext == q1_qmag);
  end

  assign dv_v[0]    = q1_valid;
  assign dv_fl[0]   = setup_fl;
  assign dv_rem1[0] = setup_fl.whole1 ? '0 : c_ext;
  assign dv_den1[0] = q1_qmag;
  assign dv_acc1[0] = '0;
  assign dv_rem2[0] = setup_fl.whole2 ? '0 : q1_qmag;
  assign dv_den2[0] = a_ext;
  assign dv_acc2[0] = '0;

  for (genvar k = 0; k < TW; k++) begin : g_div
    sci_div_cell #(
      .NUM_W (Q_W),
      .ACC_W (TW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .i_valid (dv_v[k]),
      .i_flags (dv_fl[k]),
      .i_rem1  (dv_rem1[k]),
      .i_den1  (dv_den1[k]),
      .i_acc1  (dv_acc1[k]),
      .i_rem2  (dv_rem2[k]),
      .i_den2  (dv_den2[k]),
      .i_acc2  (dv_acc2[k]),
      .o_valid (dv_v[k+1]),
      .o_flags (dv_fl[k+1]),
      .o_rem1  (dv_rem1[k+1]),
      .o_den1  (dv_den1[k+1]),
      .o_acc1  (dv_acc1[k+1]),
      .o_rem2  (dv_rem2[k+1]),
      .o_den2  (dv_den2[k+1]),
      .o_acc2  (dv_acc2[k+1])
    );
  end

  // Round the quotients and order the accepted roots
  assign t1 = t_round(dv_fl[TW].whole1, dv_acc1[TW]);
  assign t2 = t_round(dv_fl[TW].whole2, dv_acc2[TW]);

  always_comb begin
    count_next = 2'd0;
    near_next  = '0;
    far_next   = '0;
    if (dv_fl[TW].ok1) begin
      near_next  = t1;
      count_next = 2'd1;
    end
    if (dv_fl[TW].ok2) begin
      if (dv_fl[TW].ok1 && (t2 < t1)) begin
        near_next  = t2;
        far_next   = t1;
        count_next = 2'd2;
      end else if (dv_fl[TW].ok1) begin
        far_next   = t2;
        count_next = 2'd2;
      end else begin
        near_next  = t2;
        count_next = 2'd1;
      end
    end
  end

  // Output register: load when empty or when the held beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      out_valid <= dv_v[TW];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      hit_count  <= count_next;
      t_near     <= near_next;
      t_far      <= far_next;
      degenerate <= dv_fl[TW].degen;
    end
  end

endmodule

// ===== src/sci_checker.sv =====
// Port-level checks on the intersection block's results.
// Attached to segment_circle_intersect by the bind at the end of this file.
module sci_checker #(
  parameter int T_FRAC_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [1:0]             hit_count,
  input logic [T_FRAC_BITS:0]   t_near,
  input logic [T_FRAC_BITS:0]   t_far,
  input logic                   degenerate
);

  localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_count) && $stable(t_near))
    else $error("result beat changed while stalled");

  // A degenerate segment reports no crossing
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> hit_count == 2'd0 && t_near == '0)
    else $error("degenerate segment with crossings");

  // Two crossings come nearest first
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_count == 2'd2 |-> t_near <= t_far)
    else $error("crossings out of order");

  // Unused far slot reads zero and the count stays in range
  a_far: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_count != 2'd2 |-> t_far == '0 && hit_count != 2'd3)
    else $error("far parameter or count out of range");

  // Parameters never pass 1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> t_near <= T_ONE && t_far <= T_ONE)
    else $error("parameter above 1.0");

endmodule

bind segment_circle_intersect sci_checker #(
  .T_FRAC_BITS (T_FRAC_BITS)
) u_sci_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hit_count  (hit_count),
  .t_near     (t_near),
  .t_far      (t_far),
  .degenerate (degenerate)
);
